[rtl/fbpa_pkg.sv]
`timescale 1ns / 1ps
package fbpa_pkg;

  localparam int SLOT_COUNT_W  = 9;
  localparam int OBJ_BYTES_W   = 13;
  localparam int OFFSET_W      = 20;
  localparam int BYTES_W       = 21;
  localparam int CFG_DATA_W    = 13;
  localparam int CFG_IDX_W     = 1;
  localparam int MIN_OBJ_BYTES = 8;
  localparam int SLOT_COUNT_RST = 256;
  localparam int OBJ_BYTES_RST  = 64;
  localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOT_COUNT   = 1'b0,
    CFG_OBJECT_BYTES = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LINK,
    BK_DIV,
    BK_FREE,
    BK_MUL,
    BK_DONE
  } bk_state_e;

  typedef struct packed {
    logic [1:0]          command;
    logic [OFFSET_W-1:0] free_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [OFFSET_W-1:0] alloc_offset;
    logic [BYTES_W-1:0]  used_bytes;
    logic [BYTES_W-1:0]  peak_bytes;
  } out_item_t;

  typedef struct packed {
    logic [1:0]          command;
    logic [OFFSET_W-1:0] free_offset;
    logic                in_range;
  } req_entry_t;

endpackage

[rtl/fbpa_front.sv]
`timescale 1ns / 1ps
module fbpa_front
  import fbpa_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  in_item_t                         in_item_i,
  input  logic [$clog2(SLOTS+1)-1:0]       count_i,
  input  logic [OBJ_BYTES_W-1:0]           size_i,
  output logic                             req_valid_o,
  input  logic                             req_ready_i,
  output req_entry_t                       req_o
);

  localparam int SLOT_W = $clog2(SLOTS + 1);
  localparam int LIM_W  = SLOT_W + OBJ_BYTES_W;
  localparam int CMP_W  = (LIM_W > OFFSET_W) ? LIM_W : OFFSET_W;

  logic             valid_q, valid_d;
  req_entry_t       req_q, req_d;
  logic [LIM_W-1:0] limit;
  logic             take;

  // pool byte limit for the bounds check on free
  assign limit      = LIM_W'(count_i) * LIM_W'(size_i);
  assign in_ready_o = !valid_q || req_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    req_d   = req_q;
    if (take) begin
      valid_d           = 1'b1;
      req_d.command     = in_item_i.command;
      req_d.free_offset = in_item_i.free_offset;
      req_d.in_range    = CMP_W'(in_item_i.free_offset) < CMP_W'(limit);
    end else if (req_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  assign req_valid_o = valid_q;
  assign req_o       = req_q;

endmodule

[rtl/fbpa_queue.sv]
`timescale 1ns / 1ps
module fbpa_queue
  import fbpa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  req_entry_t push_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output req_entry_t pop_o
);

  req_entry_t entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_o        = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_i;
    end
  end

endmodule

[rtl/fbpa_back.sv]
`timescale 1ns / 1ps
module fbpa_back
  import fbpa_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       restart_i,
  input  logic [$clog2(SLOTS+1)-1:0] count_i,
  input  logic [OBJ_BYTES_W-1:0]     size_i,
  input  logic                       req_valid_i,
  output logic                       req_ready_o,
  input  req_entry_t                 req_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output out_item_t                  out_item_o
);

  localparam int SLOT_W = $clog2(SLOTS + 1);
  localparam int QW     = $clog2(SLOTS);
  localparam int STEP_W = $clog2(QW + 1);
  localparam int PROD_W = QW + OBJ_BYTES_W;
  localparam logic [SLOT_W-1:0] EMPTY_MARK = SLOT_W'(SLOTS);

  bk_state_e state_q, state_d;

  logic [SLOT_W-1:0]      head_q, head_d;
  logic [SLOT_W-1:0]      fresh_q, fresh_d;
  logic [BYTES_W-1:0]     used_q, used_d;
  logic [BYTES_W-1:0]     peak_q, peak_d;
  logic [QW-1:0]          slot_q, slot_d;
  logic [OBJ_BYTES_W-1:0] rem_q, rem_d;
  logic [QW-1:0]          dvd_q, dvd_d;
  logic [STEP_W-1:0]      step_q, step_d;
  logic [1:0]             status_q, status_d;
  logic [OFFSET_W-1:0]    alloc_q, alloc_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;

  logic [SLOT_W-1:0] link_mem [SLOTS];
  logic [SLOT_W-1:0] rd_data_q;
  logic              link_re, link_we;

  logic                 pop, head_live, last_step, out_free;
  logic [OBJ_BYTES_W:0] trial;
  logic                 trial_ge;
  logic [PROD_W-1:0]    prod;
  logic [BYTES_W:0]     sum;
  logic [BYTES_W-1:0]   used_add;

  assign req_ready_o = state_q == BK_IDLE;
  assign pop         = req_valid_i && req_ready_o;
  assign head_live   = head_q < EMPTY_MARK;
  assign last_step   = step_q == STEP_W'(QW - 1);
  assign out_free    = !out_valid_q || out_ready_i;

  // one restoring division step per cycle
  assign trial    = {rem_q, dvd_q[QW-1]};
  assign trial_ge = trial >= (OBJ_BYTES_W + 1)'(size_i);

  assign prod     = PROD_W'(slot_q) * PROD_W'(size_i);
  assign sum      = {1'b0, used_q} + (BYTES_W + 1)'(size_i);
  assign used_add = sum[BYTES_W] ? BYTES_MAX : sum[BYTES_W-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (pop) begin
          case (req_i.command)
            CMD_ALLOC: begin
              if (head_live) begin
                state_d = BK_LINK;
              end else if (fresh_q < count_i) begin
                state_d = BK_MUL;
              end else begin
                state_d = BK_DONE;
              end
            end
            CMD_FREE: state_d = req_i.in_range ? BK_DIV : BK_DONE;
            default:  state_d = BK_DONE;
          endcase
        end
      end
      BK_LINK: state_d = BK_MUL;
      BK_DIV:  state_d = last_step ? BK_FREE : BK_DIV;
      BK_FREE: state_d = BK_DONE;
      BK_MUL:  state_d = BK_DONE;
      BK_DONE: state_d = out_free ? BK_IDLE : BK_DONE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    head_d      = head_q;
    fresh_d     = fresh_q;
    used_d      = used_q;
    peak_d      = peak_q;
    slot_d      = slot_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    step_d      = step_q;
    status_d    = status_q;
    alloc_d     = alloc_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    link_re     = 1'b0;
    link_we     = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      BK_IDLE: begin
        if (pop) begin
          status_d = ST_OK;
          alloc_d  = '0;
          case (req_i.command)
            CMD_ALLOC: begin
              if (head_live) begin
                link_re = 1'b1;
                slot_d  = head_q[QW-1:0];
              end else if (fresh_q < count_i) begin
                slot_d  = fresh_q[QW-1:0];
                fresh_d = fresh_q + SLOT_W'(1);
              end else begin
                status_d = ST_EMPTY;
              end
            end
            CMD_FREE: begin
              if (req_i.in_range) begin
                rem_d  = OBJ_BYTES_W'(req_i.free_offset >> QW);
                dvd_d  = req_i.free_offset[QW-1:0];
                step_d = '0;
              end else begin
                status_d = ST_BAD_FREE;
              end
            end
            CMD_RESTART: begin
              head_d  = EMPTY_MARK;
              fresh_d = '0;
              used_d  = '0;
              peak_d  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      BK_LINK: begin
        head_d = (rd_data_q > EMPTY_MARK) ? EMPTY_MARK : rd_data_q;
      end
      BK_DIV: begin
        rem_d  = trial_ge ? OBJ_BYTES_W'(trial - (OBJ_BYTES_W + 1)'(size_i))
                          : OBJ_BYTES_W'(trial);
        dvd_d  = dvd_q << 1;
        slot_d = QW'({slot_q, trial_ge});
        step_d = step_q + STEP_W'(1);
      end
      BK_FREE: begin
        if (rem_q == '0) begin
          link_we = 1'b1;
          head_d  = SLOT_W'(slot_q);
          used_d  = (used_q >= BYTES_W'(size_i)) ? used_q - BYTES_W'(size_i) : '0;
        end else begin
          status_d = ST_BAD_FREE;
        end
      end
      BK_MUL: begin
        alloc_d = OFFSET_W'(prod);
        used_d  = used_add;
        peak_d  = (used_add > peak_q) ? used_add : peak_q;
      end
      BK_DONE: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.status       = status_q;
          out_d.alloc_offset = alloc_q;
          out_d.used_bytes   = used_q;
          out_d.peak_bytes   = peak_q;
        end
      end
      default: begin
      end
    endcase

    if (restart_i) begin
      head_d  = EMPTY_MARK;
      fresh_d = '0;
      used_d  = '0;
      peak_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      head_q      <= EMPTY_MARK;
      fresh_q     <= '0;
      used_q      <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fresh_q     <= fresh_d;
      used_q      <= used_d;
      peak_q      <= peak_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    rem_q    <= rem_d;
    dvd_q    <= dvd_d;
    step_q   <= step_d;
    status_q <= status_d;
    alloc_q  <= alloc_d;
    out_q    <= out_d;
  end

  // free-list links
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[slot_q] <= head_q;
    end
    if (link_re) begin
      rd_data_q <= link_mem[head_q[QW-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[rtl/fixed_block_pool_allocator.sv]
`timescale 1ns / 1ps
// channel   direction  handshake                  payload
// cfg       in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
// request   in         in_valid_i / in_ready_o    in_item_i (command, free_offset)
// result    out        out_valid_o / out_ready_i  out_item_o (status, offsets, byte counts)
// a request passes an input register and a two-entry queue before the back end runs it
// back end steps: allocate passes LINK (when reusing a freed slot) and MUL, free passes DIV
// and FREE (one quotient bit per cycle in the offset divider); an exhausted pool, an
// out-of-range free, restart and unused commands skip to DONE; one request at a time
// reset empties the pool; the link memory needs no clearing pass
// a waiting result stalls the back end; the front takes requests until queue and register fill
module fixed_block_pool_allocator
  import fbpa_pkg::*;
#(
  parameter int SLOTS            = 256,
  parameter int MAX_OBJECT_BYTES = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o
);

  localparam int SLOT_W = $clog2(SLOTS + 1);
  localparam logic [31:0] MAX_BYTES32 = MAX_OBJECT_BYTES;

  logic [SLOT_COUNT_W-1:0] slot_count_q, slot_count_d;
  logic [OBJ_BYTES_W-1:0]  object_bytes_q, object_bytes_d;
  logic                    cfg_write;
  logic [SLOT_W-1:0]       count_eff;
  logic [OBJ_BYTES_W-1:0]  size_eff;

  logic       req_valid, req_ready;
  req_entry_t req;
  logic       bk_valid, bk_ready;
  req_entry_t bk_req;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_comb begin
    slot_count_d   = slot_count_q;
    object_bytes_d = object_bytes_q;
    if (cfg_write) begin
      case (cfg_index_i)
        CFG_SLOT_COUNT:   slot_count_d   = cfg_data_i[SLOT_COUNT_W-1:0];
        CFG_OBJECT_BYTES: object_bytes_d = cfg_data_i[OBJ_BYTES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q   <= SLOT_COUNT_W'(SLOT_COUNT_RST);
      object_bytes_q <= OBJ_BYTES_W'(OBJ_BYTES_RST);
    end else begin
      slot_count_q   <= slot_count_d;
      object_bytes_q <= object_bytes_d;
    end
  end

  always_comb begin
    if (slot_count_q == '0) begin
      count_eff = SLOT_W'(1);
    end else if (32'(slot_count_q) > 32'(SLOTS)) begin
      count_eff = SLOT_W'(SLOTS);
    end else begin
      count_eff = SLOT_W'(slot_count_q);
    end
    if (object_bytes_q < OBJ_BYTES_W'(MIN_OBJ_BYTES)) begin
      size_eff = OBJ_BYTES_W'(MIN_OBJ_BYTES);
    end else if (32'(object_bytes_q) > MAX_BYTES32) begin
      size_eff = OBJ_BYTES_W'(MAX_BYTES32);
    end else begin
      size_eff = object_bytes_q;
    end
  end

  fbpa_front #(
    .SLOTS(SLOTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .count_i     (count_eff),
    .size_i      (size_eff),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready),
    .req_o       (req)
  );

  fbpa_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (req_valid),
    .push_ready_o (req_ready),
    .push_i       (req),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_o        (bk_req)
  );

  fbpa_back #(
    .SLOTS(SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (cfg_write),
    .count_i     (count_eff),
    .size_i      (size_eff),
    .req_valid_i (bk_valid),
    .req_ready_o (bk_ready),
    .req_i       (bk_req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

[verif/fbpa_checker.sv]
`timescale 1ns / 1ps
module fbpa_checker
  import fbpa_pkg::*;
#(
  parameter int SLOTS            = 256,
  parameter int MAX_OBJECT_BYTES = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_item_t              in_item_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_item_t             out_item_i,
  output int                    fail_count_o,
  output int                    results_due_o
);

  localparam int IDX_W = $clog2(SLOTS + 1);

  logic [SLOT_COUNT_W-1:0] slot_reg;
  logic [OBJ_BYTES_W-1:0]  size_reg;
  logic [IDX_W-1:0]        head;
  logic [IDX_W-1:0]        fresh;
  logic [IDX_W-1:0]        links [SLOTS];
  logic [BYTES_W-1:0]      used;
  logic [BYTES_W-1:0]      peak;
  out_item_t               replies_due [$];
  out_item_t               want;
  out_item_t               made;
  int                      fails = 0;
  int                      due = 0;

  assign fail_count_o  = fails;
  assign results_due_o = due;

  task automatic pool_restart();
    head  = IDX_W'(SLOTS);
    fresh = '0;
    used  = '0;
    peak  = '0;
  endtask

  task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_SLOT_COUNT) begin
      slot_reg = data[SLOT_COUNT_W-1:0];
    end else begin
      size_reg = data[OBJ_BYTES_W-1:0];
    end
    pool_restart();
  endtask

  task automatic pool_step(input in_item_t req, output out_item_t res);
    int unsigned      cnt;
    int unsigned      sz;
    int unsigned      slot;
    logic [BYTES_W:0] sum;
    cnt = 32'(slot_reg);
    if (cnt < 1) cnt = 1;
    if (cnt > SLOTS) cnt = SLOTS;
    sz = 32'(size_reg);
    if (sz < MIN_OBJ_BYTES) sz = MIN_OBJ_BYTES;
    if (sz > MAX_OBJECT_BYTES) sz = MAX_OBJECT_BYTES;
    res = '0;
    res.status = ST_OK;
    case (req.command)
      CMD_ALLOC: begin
        slot = SLOTS;
        if (head < SLOTS) begin
          slot = 32'(head);
          head = links[slot];
          if (head > SLOTS) head = IDX_W'(SLOTS);
        end else if (fresh < cnt) begin
          slot  = 32'(fresh);
          fresh = fresh + IDX_W'(1);
        end
        if (slot < SLOTS) begin
          res.alloc_offset = OFFSET_W'(slot * sz);
          sum = (BYTES_W + 1)'(32'(used) + sz);
          used = (sum > BYTES_MAX) ? BYTES_MAX : sum[BYTES_W-1:0];
          if (used > peak) peak = used;
        end else begin
          res.status = ST_EMPTY;
        end
      end
      CMD_FREE: begin
        if (req.free_offset < cnt * sz && req.free_offset % sz == 0) begin
          slot = req.free_offset / sz;
          links[slot] = head;
          head = IDX_W'(slot);
          used = (used >= sz) ? BYTES_W'(32'(used) - sz) : '0;
        end else begin
          res.status = ST_BAD_FREE;
        end
      end
      CMD_RESTART: pool_restart();
      default: ;
    endcase
    res.used_bytes = used;
    res.peak_bytes = peak;
  endtask

  function automatic void check_field(string name, logic [31:0] expd, logic [31:0] seen);
    if (seen !== expd) begin
      $error("%s: expected %0d, actual %0d", name, expd, seen);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_reg = SLOT_COUNT_W'(SLOT_COUNT_RST);
      size_reg = OBJ_BYTES_W'(OBJ_BYTES_RST);
      pool_restart();
      replies_due.delete();
      due = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (replies_due.size() == 0) begin
          $error("result with no request waiting: status %0d offset %0d",
                 out_item_i.status, out_item_i.alloc_offset);
          fails++;
        end else begin
          want = replies_due.pop_front();
          check_field("status", want.status, out_item_i.status);
          check_field("alloc_offset", want.alloc_offset, out_item_i.alloc_offset);
          check_field("used_bytes", want.used_bytes, out_item_i.used_bytes);
          check_field("peak_bytes", want.peak_bytes, out_item_i.peak_bytes);
        end
      end
      if (cfg_valid_i && cfg_ready_i) apply_reg_write(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i) begin
        pool_step(in_item_i, made);
        replies_due.push_back(made);
      end
      due = replies_due.size();
    end
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
module tb;
  import fbpa_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         STALL_LIMIT = 2000;
  localparam int         HELD_MAX    = 512;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_item;
  int                    fail_count;
  int                    results_due;

  int                    cur_slots = SLOT_COUNT_RST;
  int                    cur_size = OBJ_BYTES_RST;
  int                    alloc_pct = 50;
  int                    idle_cycles = 0;
  bit                    rx_hold_go = 1'b0;
  bit                    rx_hold_done = 1'b0;
  logic [1:0]            sent_cmds [$];
  logic [1:0]            done_cmd;
  logic [OFFSET_W-1:0]   held [$];

  fixed_block_pool_allocator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  fbpa_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_item_i     (in_item),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_item_i    (out_item),
    .fail_count_o  (fail_count),
    .results_due_o (results_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // remember handed-out offsets so that most frees are well formed
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      done_cmd = sent_cmds.pop_front();
      if (done_cmd == CMD_ALLOC && out_item.status == ST_OK) begin
        if (held.size() < HELD_MAX) held.push_back(out_item.alloc_offset);
      end else if (done_cmd == CMD_RESTART) begin
        held.delete();
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int seg_left;
    int pct;
    seg_left  = 0;
    pct       = 100;
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_go && !rx_hold_done) begin
        out_ready <= 1'b0;
        repeat (150) @(negedge clk_i);
        rx_hold_done = 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(1, 40);
          case ($urandom_range(3))
            0: pct = 100;
            1: pct = 70;
            2: pct = 40;
            default: pct = 10;
          endcase
        end
        seg_left--;
        out_ready <= ($urandom_range(99) < pct);
      end
    end
  end

  function automatic in_item_t mk(logic [1:0] cmd, logic [OFFSET_W-1:0] off);
    in_item_t it;
    it.command     = cmd;
    it.free_offset = off;
    return it;
  endfunction

  function automatic in_item_t make_req();
    in_item_t it;
    int       r;
    int       k;
    r = $urandom_range(99);
    it.free_offset = OFFSET_W'($urandom);
    if (r < alloc_pct || (r < 85 && held.size() == 0)) begin
      it.command = CMD_ALLOC;
    end else if (r < 85) begin
      k = $urandom_range(held.size() - 1);
      it.command     = CMD_FREE;
      it.free_offset = held[k];
      held.delete(k);
    end else if (r < 90) begin
      it.command     = CMD_FREE;
      it.free_offset = OFFSET_W'($urandom_range(cur_slots - 1) * cur_size);
    end else if (r < 93) begin
      it.command = CMD_FREE;
    end else if (r < 96) begin
      it.command     = CMD_FREE;
      it.free_offset = OFFSET_W'((cur_slots + $urandom_range(3)) * cur_size);
    end else if (r < 98) begin
      it.command = CMD_RESTART;
    end else begin
      it.command = CMD_UNUSED;
    end
    return it;
  endfunction

  task automatic send_req(input in_item_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (!in_ready);
    sent_cmds.push_back(it.command);
    @(negedge clk_i);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (results_due != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    int v;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == CFG_SLOT_COUNT) begin
      v = val[SLOT_COUNT_W-1:0];
      cur_slots = (v < 1) ? 1 : (v > 256) ? 256 : v;
    end else begin
      v = val;
      cur_size = (v < MIN_OBJ_BYTES) ? MIN_OBJ_BYTES : (v > 4096) ? 4096 : v;
    end
    held.delete();
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] slots,
                           input logic [CFG_DATA_W-1:0] size);
    write_reg(CFG_SLOT_COUNT, slots);
    write_reg(CFG_OBJECT_BYTES, size);
  endtask

  task automatic run_phase(input int n, input int apct);
    int left;
    int burst;
    alloc_pct = apct;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      if (burst > left) burst = left;
      repeat (burst) send_req(make_req());
      left -= burst;
      if ($urandom_range(3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end
    end
    quiesce();
  endtask

  initial begin
    rst_ni    = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SLOT_COUNT;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_item   = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset config: double free, free with nothing in use, bad frees
    send_req(mk(CMD_ALLOC, '0));
    send_req(mk(CMD_ALLOC, '1));
    send_req(mk(CMD_FREE, 20'd64));
    send_req(mk(CMD_FREE, 20'd0));
    send_req(mk(CMD_FREE, 20'd0));
    send_req(mk(CMD_ALLOC, '0));
    send_req(mk(CMD_ALLOC, '0));
    send_req(mk(CMD_RESTART, '1));
    send_req(mk(CMD_FREE, 20'hFFFFF));
    send_req(mk(CMD_FREE, 20'd32));
    send_req(mk(CMD_FREE, 20'd16384));
    send_req(mk(CMD_UNUSED, 20'hFFFFF));
    send_req(mk(CMD_ALLOC, '0));
    quiesce();

    // zero slots and undersized objects clamp
    configure(13'd0, 13'd0);
    send_req(mk(CMD_ALLOC, '0));
    send_req(mk(CMD_ALLOC, '0));
    send_req(mk(CMD_FREE, 20'd0));
    send_req(mk(CMD_ALLOC, '0));
    send_req(mk(CMD_ALLOC, '0));
    quiesce();

    // oversized values clamp, top slot offset
    configure(13'h1FFF, 13'h1FFF);
    send_req(mk(CMD_ALLOC, '0));
    send_req(mk(CMD_FREE, 20'hFF000));
    send_req(mk(CMD_ALLOC, '0));
    send_req(mk(CMD_FREE, 20'hFF000));
    quiesce();

    configure(13'd256, 13'd8);
    rx_hold_go = 1'b1;
    run_phase(300, 60);
    run_phase(200, 45);
    configure(13'd1, 13'd4096);
    run_phase(150, 50);
    configure(13'd0, 13'd7);
    run_phase(100, 50);
    configure(13'($urandom_range(2, 20)), 13'($urandom_range(8, 300)));
    run_phase(250, 55);
    configure(13'd256, 13'd4096);
    run_phase(400, 80);
    repeat (4) begin
      configure(13'($urandom), 13'($urandom));
      run_phase(110, $urandom_range(35, 70));
    end

    repeat (30) @(negedge clk_i);
    if (fail_count == 0 && results_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
